>>> design/swum_pkg.sv
// shared types and constants of the sliding window usage meter
`default_nettype none

package swum_pkg;

    localparam int CNT_W        = 16;
    localparam int SUM_W        = 20;
    localparam int CAP_W        = 21;
    localparam int TOT_W        = SUM_W + 1;
    localparam int PCT_W        = 7;
    localparam int DIVIDEND_W   = SUM_W + PCT_W;
    localparam int PCT_STEPS    = 7;
    localparam int PCT_CNT_W    = $clog2(PCT_STEPS);
    localparam int BIT_CNT_W    = $clog2(SUM_W);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);
    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);

    typedef enum logic
    {
        ACT_ADD   = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] ticks;
    } sample_t;

    typedef struct packed
    {
        logic load;
        logic clear;
        logic shift;
    } lane_ctl_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SHIFT,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> design/sliding_window_usage_meter_unit.sv
// sliding window usage meter: ring of samples, serial window sums, percentages
//
//  channel   direction  handshake              contents
//  in        sink       in_valid / in_ready    action, count_a..count_d, tick_count
//  out       source     out_valid / out_ready  percents, usages, excess flags, window_ticks
//  cfg       sink       cfg_wr_en              capacity (cfg_wr_data)
//
// each transaction passes in order through a ring read, a load, the bit-serial sum update,
// a divider start, the quotient steps, the registered done flag and the load into the
// output register. a new transaction is accepted only in the idle state after that load,
// so the unit never takes a new transaction before it is through with the last one.
// reset empties the ring (per-slot valid bits) and zeroes the sums; capacity is 65536.
// a stalled output holds the following result in the final state until it drains.
`default_nettype none

module sliding_window_usage_meter_unit
    import swum_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             action,
    input  wire logic [CNT_W-1:0] count_a,
    input  wire logic [CNT_W-1:0] count_b,
    input  wire logic [CNT_W-1:0] count_c,
    input  wire logic [CNT_W-1:0] count_d,
    input  wire logic [CNT_W-1:0] tick_count,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [PCT_W-1:0]      lower_percent,
    output logic [PCT_W-1:0]      upper_percent,
    output logic [CAP_W-1:0]      lower_usage,
    output logic [CAP_W-1:0]      upper_usage,
    output logic                  lower_excess,
    output logic                  upper_excess,
    output logic [SUM_W-1:0]      window_ticks,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);

    state_t                  state_reg;
    state_t                  state_next;
    logic [PTR_W-1:0]        pos_reg;
    logic [PTR_W-1:0]        pos_inc;
    logic [PTR_W-1:0]        slot_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic                    old_valid_reg;
    action_t                 act_reg;
    sample_t                 fresh_reg;
    sample_t                 rd_reg;
    sample_t                 old_word;
    sample_t                 ring_mem [WINDOW_DEPTH];
    logic [CAP_W-1:0]        capacity_reg;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg;

    logic [SUM_W-1:0]        tot_lo_reg;
    logic [SUM_W-1:0]        tot_hi_reg;
    logic                    tot_lo_c_reg;
    logic                    tot_hi_c_reg;
    logic [TOT_W-1:0]        total_lo;
    logic [TOT_W-1:0]        total_hi;

    logic                    in_accept;
    logic                    mem_re;
    logic                    mem_we;
    logic                    div_start;
    logic                    out_load;
    lane_ctl_t               lctl;

    logic                    bit_a;
    logic                    bit_b;
    logic                    bit_c;
    logic                    bit_d;
    logic [SUM_W-1:0]        sum_a;
    logic [SUM_W-1:0]        sum_b;
    logic [SUM_W-1:0]        sum_c;
    logic [SUM_W-1:0]        sum_d;
    logic [SUM_W-1:0]        sum_ticks;
    logic                    lo_done;
    logic                    hi_done;
    logic [PCT_W-1:0]        lo_pct;
    logic [PCT_W-1:0]        hi_pct;

    logic                    out_valid_reg;
    logic [PCT_W-1:0]        lower_percent_reg;
    logic [PCT_W-1:0]        upper_percent_reg;
    logic [CAP_W-1:0]        lower_usage_reg;
    logic [CAP_W-1:0]        upper_usage_reg;
    logic                    lower_excess_reg;
    logic                    upper_excess_reg;
    logic [SUM_W-1:0]        window_ticks_reg;

    assign in_accept = in_valid && in_ready;
    assign pos_inc   = (pos_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign old_word  = old_valid_reg ? rd_reg : '0;
    assign total_lo  = {tot_lo_c_reg, tot_lo_reg};
    assign total_hi  = {tot_hi_c_reg, tot_hi_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SHIFT;
            ST_SHIFT: if (bit_cnt_reg == BIT_CNT_W'(SUM_W - 1)) state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (lo_done && hi_done) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        lctl       = '0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_READ:  mem_re = 1'b1;
            ST_LOAD:
            begin
                lctl.load  = 1'b1;
                lctl.clear = (act_reg == ACT_CLEAR);
                mem_we     = (act_reg == ACT_ADD);
            end
            ST_SHIFT: lctl.shift = 1'b1;
            ST_START: div_start = 1'b1;
            ST_DIV:   ;
            ST_DONE:  out_load = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            valid_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            if (in_accept)
            begin
                if (action == ACT_CLEAR)
                    valid_reg <= '0;
                else
                    pos_reg <= pos_inc;
            end
            if (mem_we)
                valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg         <= action_t'(action);
            slot_reg        <= pos_inc;
            fresh_reg.a     <= count_a;
            fresh_reg.b     <= count_b;
            fresh_reg.c     <= count_c;
            fresh_reg.d     <= count_d;
            fresh_reg.ticks <= tick_count;
        end
        if (mem_re)
            old_valid_reg <= valid_reg[slot_reg] && (act_reg == ACT_ADD);
    end

    // ring storage, read and written on separate cycles
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[slot_reg] <= fresh_reg;
        if (mem_re)
            rd_reg <= ring_mem[slot_reg];
    end

    // serial pair totals, fed by the new sum bits of the lanes
    always_ff @(posedge clk)
    begin
        if (lctl.load)
        begin
            bit_cnt_reg  <= '0;
            tot_lo_c_reg <= 1'b0;
            tot_hi_c_reg <= 1'b0;
        end
        else if (lctl.shift)
        begin
            bit_cnt_reg  <= bit_cnt_reg + 1'b1;
            tot_lo_reg   <= {bit_a ^ bit_b ^ tot_lo_c_reg, tot_lo_reg[SUM_W-1:1]};
            tot_lo_c_reg <= (bit_a & bit_b) | (bit_a & tot_lo_c_reg) | (bit_b & tot_lo_c_reg);
            tot_hi_reg   <= {bit_c ^ bit_d ^ tot_hi_c_reg, tot_hi_reg[SUM_W-1:1]};
            tot_hi_c_reg <= (bit_c & bit_d) | (bit_c & tot_hi_c_reg) | (bit_d & tot_hi_c_reg);
        end
    end

    swum_lane u_lane_a
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lctl),
        .fresh   (act_reg == ACT_CLEAR ? '0 : fresh_reg.a),
        .old     (old_word.a),
        .bit_out (bit_a),
        .sum     (sum_a)
    );

    swum_lane u_lane_b
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lctl),
        .fresh   (act_reg == ACT_CLEAR ? '0 : fresh_reg.b),
        .old     (old_word.b),
        .bit_out (bit_b),
        .sum     (sum_b)
    );

    swum_lane u_lane_c
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lctl),
        .fresh   (act_reg == ACT_CLEAR ? '0 : fresh_reg.c),
        .old     (old_word.c),
        .bit_out (bit_c),
        .sum     (sum_c)
    );

    swum_lane u_lane_d
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lctl),
        .fresh   (act_reg == ACT_CLEAR ? '0 : fresh_reg.d),
        .old     (old_word.d),
        .bit_out (bit_d),
        .sum     (sum_d)
    );

    swum_lane u_lane_ticks
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lctl),
        .fresh   (act_reg == ACT_CLEAR ? '0 : fresh_reg.ticks),
        .old     (old_word.ticks),
        .bit_out (),
        .sum     (sum_ticks)
    );

    swum_pct u_pct_lo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .first   (sum_a),
        .total   (total_lo),
        .done    (lo_done),
        .percent (lo_pct)
    );

    // runs in lockstep with the lower divider
    swum_pct u_pct_hi
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .first   (sum_c),
        .total   (total_hi),
        .done    (hi_done),
        .percent (hi_pct)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            lower_percent_reg <= lo_pct;
            upper_percent_reg <= hi_pct;
            lower_usage_reg   <= (total_lo <= capacity_reg) ? total_lo : capacity_reg;
            upper_usage_reg   <= (total_hi <= capacity_reg) ? total_hi : capacity_reg;
            lower_excess_reg  <= {1'b0, total_lo} > {capacity_reg, 1'b0};
            upper_excess_reg  <= {1'b0, total_hi} > {capacity_reg, 1'b0};
            window_ticks_reg  <= sum_ticks;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lower_percent = lower_percent_reg;
    assign upper_percent = upper_percent_reg;
    assign lower_usage   = lower_usage_reg;
    assign upper_usage   = upper_usage_reg;
    assign lower_excess  = lower_excess_reg;
    assign upper_excess  = upper_excess_reg;
    assign window_ticks  = window_ticks_reg;

endmodule

`default_nettype wire

>>> design/swum_lane.sv
// bit-serial running sum: adds the new value and removes the evicted one
`default_nettype none

module swum_lane
    import swum_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_ctl_t        ctl,
    input  wire logic [CNT_W-1:0] fresh,
    input  wire logic [CNT_W-1:0] old,
    output logic                  bit_out,
    output logic [SUM_W-1:0]      sum
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] fresh_reg;
    logic [SUM_W-1:0] old_reg;
    logic             carry_reg;
    logic             borrow_reg;
    logic             part_bit;
    logic             carry_next;
    logic             borrow_next;

    // sum + fresh, then minus old, one bit per cycle from the lsb
    always_comb
    begin
        part_bit    = sum_reg[0] ^ fresh_reg[0] ^ carry_reg;
        carry_next  = (sum_reg[0] & fresh_reg[0]) | (sum_reg[0] & carry_reg)
                    | (fresh_reg[0] & carry_reg);
        bit_out     = part_bit ^ old_reg[0] ^ borrow_reg;
        borrow_next = (~part_bit & old_reg[0]) | (~(part_bit ^ old_reg[0]) & borrow_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.load && ctl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctl.shift)
        begin
            sum_reg <= {bit_out, sum_reg[SUM_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            fresh_reg  <= {{(SUM_W-CNT_W){1'b0}}, fresh};
            old_reg    <= {{(SUM_W-CNT_W){1'b0}}, old};
            carry_reg  <= 1'b0;
            borrow_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            fresh_reg  <= {1'b0, fresh_reg[SUM_W-1:1]};
            old_reg    <= {1'b0, old_reg[SUM_W-1:1]};
            carry_reg  <= carry_next;
            borrow_reg <= borrow_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> design/swum_pct.sv
// restoring divider for first * 100 / total, one quotient bit per cycle
`default_nettype none

module swum_pct
    import swum_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] first,
    input  wire logic [TOT_W-1:0] total,
    output logic                  done,
    output logic [PCT_W-1:0]      percent
);

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVIDEND_W-1:0] dsr_reg;
    logic [PCT_W-1:0]      quo_reg;
    logic [PCT_CNT_W-1:0]  cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic                  zero_reg;
    logic [DIVIDEND_W:0]   diff;
    logic [DIVIDEND_W-1:0] first_ext;
    logic                  fits;

    assign first_ext = {{PCT_W{1'b0}}, first};
    assign diff      = {1'b0, rem_reg} - {1'b0, dsr_reg};
    assign fits      = ~diff[DIVIDEND_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (start)
                run_reg <= 1'b1;
            else if (run_reg && (cnt_reg == '0))
                run_reg <= 1'b0;
        end
    end

    // quotient never exceeds 100, so seven steps cover it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= (first_ext << 6) + (first_ext << 5) + (first_ext << 2);
            dsr_reg  <= {total, {(PCT_STEPS-1){1'b0}}};
            quo_reg  <= '0;
            cnt_reg  <= PCT_CNT_W'(PCT_STEPS - 1);
            zero_reg <= (total == '0);
        end
        else if (run_reg)
        begin
            if (fits)
                rem_reg <= diff[DIVIDEND_W-1:0];
            quo_reg <= {quo_reg[PCT_W-2:0], fits};
            dsr_reg <= {1'b0, dsr_reg[DIVIDEND_W-1:1]};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done    = done_reg;
    assign percent = zero_reg ? PCT_FULL : quo_reg;

endmodule

`default_nettype wire

>>> tb/usage_meter_checker.sv
// checker for the usage meter: watches the in, out and cfg channels, predicts readings and compares them
module usage_meter_checker
    import swum_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             action,
    input  logic [CNT_W-1:0] count_a,
    input  logic [CNT_W-1:0] count_b,
    input  logic [CNT_W-1:0] count_c,
    input  logic [CNT_W-1:0] count_d,
    input  logic [CNT_W-1:0] tick_count,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [PCT_W-1:0] lower_percent,
    input  logic [PCT_W-1:0] upper_percent,
    input  logic [CAP_W-1:0] lower_usage,
    input  logic [CAP_W-1:0] upper_usage,
    input  logic             lower_excess,
    input  logic             upper_excess,
    input  logic [SUM_W-1:0] window_ticks,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    output int               mismatches,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef struct packed
    {
        logic [PCT_W-1:0] lower_percent;
        logic [PCT_W-1:0] upper_percent;
        logic [CAP_W-1:0] lower_usage;
        logic [CAP_W-1:0] upper_usage;
        logic             lower_excess;
        logic             upper_excess;
        logic [SUM_W-1:0] window_ticks;
    } reading_t;

    sample_t          ring [WINDOW_DEPTH];
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_c;
    logic [SUM_W-1:0] sum_d;
    logic [SUM_W-1:0] sum_ticks;
    logic [POS_W-1:0] position;
    logic [CAP_W-1:0] capacity;
    reading_t         expected_readings [$];
    int               fail_count;
    int               reading_no;

    assign mismatches = fail_count;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic void empty_window();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            ring[i] = '0;
        sum_a     = '0;
        sum_b     = '0;
        sum_c     = '0;
        sum_d     = '0;
        sum_ticks = '0;
    endfunction

    // share of the first count in the pair, 100 when the pair is empty
    function automatic logic [PCT_W-1:0] pair_share(logic [SUM_W-1:0] first,
                                                    logic [SUM_W-1:0] second);
        logic [TOT_W-1:0] total;
        total = TOT_W'(first) + TOT_W'(second);
        if (total == '0)
            return PCT_FULL;
        return PCT_W'((64'(first) * 64'(PCT_FULL)) / 64'(total));
    endfunction

    function automatic logic [CAP_W-1:0] pair_load(logic [SUM_W-1:0] first,
                                                   logic [SUM_W-1:0] second);
        logic [TOT_W-1:0] total;
        total = TOT_W'(first) + TOT_W'(second);
        return (total <= capacity) ? total : capacity;
    endfunction

    function automatic logic pair_over(logic [SUM_W-1:0] first, logic [SUM_W-1:0] second);
        logic [TOT_W:0] total;
        total = (TOT_W+1)'(first) + (TOT_W+1)'(second);
        return total > ((TOT_W+1)'(capacity) << 1);
    endfunction

    function automatic reading_t slide_window(logic act, sample_t s);
        reading_t         r;
        logic [POS_W-1:0] slot;
        if (act == ACT_CLEAR)
        begin
            empty_window();
        end
        else
        begin
            slot      = (position >= POS_W'(WINDOW_DEPTH - 1)) ? '0 : position + 1'b1;
            sum_a     = sum_a + SUM_W'(s.a) - SUM_W'(ring[slot].a);
            sum_b     = sum_b + SUM_W'(s.b) - SUM_W'(ring[slot].b);
            sum_c     = sum_c + SUM_W'(s.c) - SUM_W'(ring[slot].c);
            sum_d     = sum_d + SUM_W'(s.d) - SUM_W'(ring[slot].d);
            sum_ticks = sum_ticks + SUM_W'(s.ticks) - SUM_W'(ring[slot].ticks);
            ring[slot] = s;
            position   = slot;
        end
        r.lower_percent = pair_share(sum_a, sum_b);
        r.upper_percent = pair_share(sum_c, sum_d);
        r.lower_usage   = pair_load(sum_a, sum_b);
        r.upper_usage   = pair_load(sum_c, sum_d);
        r.lower_excess  = pair_over(sum_a, sum_b);
        r.upper_excess  = pair_over(sum_c, sum_d);
        r.window_ticks  = sum_ticks;
        return r;
    endfunction

    task automatic compare_reading(reading_t got, reading_t want);
        if (got.lower_percent !== want.lower_percent)
            report($sformatf("reading %0d lower_percent got %0d expected %0d",
                             reading_no, got.lower_percent, want.lower_percent));
        if (got.upper_percent !== want.upper_percent)
            report($sformatf("reading %0d upper_percent got %0d expected %0d",
                             reading_no, got.upper_percent, want.upper_percent));
        if (got.lower_usage !== want.lower_usage)
            report($sformatf("reading %0d lower_usage got %0d expected %0d",
                             reading_no, got.lower_usage, want.lower_usage));
        if (got.upper_usage !== want.upper_usage)
            report($sformatf("reading %0d upper_usage got %0d expected %0d",
                             reading_no, got.upper_usage, want.upper_usage));
        if (got.lower_excess !== want.lower_excess)
            report($sformatf("reading %0d lower_excess got %0d expected %0d",
                             reading_no, got.lower_excess, want.lower_excess));
        if (got.upper_excess !== want.upper_excess)
            report($sformatf("reading %0d upper_excess got %0d expected %0d",
                             reading_no, got.upper_excess, want.upper_excess));
        if (got.window_ticks !== want.window_ticks)
            report($sformatf("reading %0d window_ticks got %0d expected %0d",
                             reading_no, got.window_ticks, want.window_ticks));
    endtask

    initial
    begin
        fail_count = 0;
        reading_no = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_window();
            position = '0;
            capacity = CAP_RESET;
            expected_readings.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                    report($sformatf("reading %0d arrived with nothing outstanding",
                                     reading_no));
                else
                    compare_reading({lower_percent, upper_percent, lower_usage, upper_usage,
                                     lower_excess, upper_excess, window_ticks},
                                    expected_readings.pop_front());
                reading_no++;
            end
            if (in_valid && in_ready)
                expected_readings.push_back(slide_window(action, {count_a, count_b, count_c,
                                                                  count_d, tick_count}));
            pending <= expected_readings.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// top of the usage meter testbench: clock, reset, stimulus, watchdog and verdict
module tb_top;
    import swum_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 66;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    action_t          action      = ACT_ADD;
    logic [CNT_W-1:0] count_a     = '0;
    logic [CNT_W-1:0] count_b     = '0;
    logic [CNT_W-1:0] count_c     = '0;
    logic [CNT_W-1:0] count_d     = '0;
    logic [CNT_W-1:0] tick_count  = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic [PCT_W-1:0] lower_percent;
    logic [PCT_W-1:0] upper_percent;
    logic [CAP_W-1:0] lower_usage;
    logic [CAP_W-1:0] upper_usage;
    logic             lower_excess;
    logic             upper_excess;
    logic [SUM_W-1:0] window_ticks;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    int               mismatches;
    int               pending;
    bit               no_idle     = 1'b0;

    sliding_window_usage_meter_unit #(.WINDOW_DEPTH(DEPTH)) u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .count_a       (count_a),
        .count_b       (count_b),
        .count_c       (count_c),
        .count_d       (count_d),
        .tick_count    (tick_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lower_percent (lower_percent),
        .upper_percent (upper_percent),
        .lower_usage   (lower_usage),
        .upper_usage   (upper_usage),
        .lower_excess  (lower_excess),
        .upper_excess  (upper_excess),
        .window_ticks  (window_ticks),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    usage_meter_checker #(.WINDOW_DEPTH(DEPTH)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .count_a       (count_a),
        .count_b       (count_b),
        .count_c       (count_c),
        .count_d       (count_d),
        .tick_count    (tick_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lower_percent (lower_percent),
        .upper_percent (upper_percent),
        .lower_usage   (lower_usage),
        .upper_usage   (upper_usage),
        .lower_excess  (lower_excess),
        .upper_excess  (upper_excess),
        .window_ticks  (window_ticks),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // counts skew toward the extremes so the window sums reach clamp and excess
    function automatic logic [CNT_W-1:0] draw_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CNT_W'($urandom_range(0, 15));
            3, 4:    return CNT_W'($urandom_range(60000, 65535));
            default: return CNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic sample_t draw_sample();
        sample_t s;
        s.a     = draw_count();
        s.b     = draw_count();
        s.c     = draw_count();
        s.d     = draw_count();
        s.ticks = draw_count();
        return s;
    endfunction

    task automatic offer(action_t act, sample_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        count_a    <= s.a;
        count_b    <= s.b;
        count_c    <= s.c;
        count_d    <= s.d;
        tick_count <= s.ticks;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // hold off the sender until every outstanding reading has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver side
    initial
    begin
        int gap;
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap;
        action_t          act;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset capacity
        offer(ACT_ADD, '0);
        offer(ACT_ADD, '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
        offer(ACT_ADD, '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
        offer(ACT_CLEAR, '{16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF});
        offer(ACT_ADD, '{16'd1, 16'd2, 16'd2, 16'd1, 16'd3});
        // fill the ring with maxima and wrap so old slots get evicted
        repeat (DEPTH + 1) offer(ACT_ADD, '1);
        offer(ACT_CLEAR, '1);
        offer(ACT_ADD, '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1});

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       cap = CAP_W'(1);
                1:       cap = '1;
                2:       cap = '0;
                3:       cap = CAP_RESET;
                4:       cap = CAP_W'(1048560);
                5:       cap = CAP_W'($urandom_range(1, 2097151));
                6:       cap = CAP_W'($urandom_range(1, 300000));
                default: cap = CAP_W'($urandom_range(1000000, 2097151));
            endcase
            set_capacity(cap);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 23 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (n == 35 || $urandom_range(0, 49) == 0)
                    drain();
                act = ($urandom_range(0, 29) == 0) ? ACT_CLEAR : ACT_ADD;
                offer(act, draw_sample());
            end
        end

        no_idle = 1'b0;
        drain();
        repeat (64) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
